@@ design/rgb_to_hsv_pixel_macros.svh @@
// Assertion macros used by the top-level design file.
// RHP_ASSERT checks a property at every rising clock edge outside reset.
// RHP_ASSERT_ALWAYS checks a property at every rising clock edge, reset included.
`ifndef RGB_TO_HSV_PIXEL_MACROS_SVH
`define RGB_TO_HSV_PIXEL_MACROS_SVH

`ifndef SYNTH
`define RHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rgb_to_hsv_pixel: assertion failed");
`define RHP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("rgb_to_hsv_pixel: assertion failed during or after reset");
`else
`define RHP_ASSERT(lbl, prop)
`define RHP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ design/rhp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rhp_pkg;

  // Number of quotient bits, and so of divider cells in the chain.
  localparam int unsigned QuoBits = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [7:0]  value;
    logic [7:0]  alpha_out;
  } pix_out_t;

  // Everything one cell of the chain holds for one pixel.
  typedef struct packed {
    logic [10:0] hrem;   // hue partial remainder, below hdiv
    logic [10:0] hdiv;   // six times delta
    logic [15:0] hquo;   // hue quotient bits so far
    logic [7:0]  srem;   // saturation partial remainder, below sdiv
    logic [7:0]  sdiv;   // largest channel
    logic [15:0] slow;   // saturation dividend bits still to bring down
    logic [15:0] squo;   // saturation quotient bits so far
    logic [7:0]  value;
    logic [7:0]  alpha;
    logic        gray;   // all channels equal: hue and saturation are zero
  } cell_t;

endpackage

`default_nettype wire

@@ design/rhp_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhp_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            up_valid_i,
  input  rhp_pkg::pix_in_t up_word_i,
  output logic            up_ready_o,
  output logic            dn_valid_o,
  output rhp_pkg::cell_t  dn_data_o,
  input  logic            dn_ready_i
);

  logic [7:0]         mx, mn, delta;
  logic               red_max, green_max;
  logic signed [11:0] r_s, g_s, b_s, d_s, term, term_w;
  logic [10:0]        six_delta;
  logic [23:0]        s_num;
  rhp_pkg::cell_t     nxt;
  logic               valid_q;
  rhp_pkg::cell_t     data_q;

  always_comb begin
    red_max   = (up_word_i.red >= up_word_i.green) && (up_word_i.red >= up_word_i.blue);
    green_max = !red_max && (up_word_i.green >= up_word_i.blue);
    if (red_max) begin
      mx = up_word_i.red;
    end else if (green_max) begin
      mx = up_word_i.green;
    end else begin
      mx = up_word_i.blue;
    end
    mn = up_word_i.red;
    if (up_word_i.green < mn) begin
      mn = up_word_i.green;
    end
    if (up_word_i.blue < mn) begin
      mn = up_word_i.blue;
    end
    delta = mx - mn;

    r_s = signed'({4'b0, up_word_i.red});
    g_s = signed'({4'b0, up_word_i.green});
    b_s = signed'({4'b0, up_word_i.blue});
    d_s = signed'({4'b0, delta});
    if (red_max) begin
      term = g_s - b_s;
    end else if (green_max) begin
      term = (d_s <<< 1) + b_s - r_s;
    end else begin
      term = (d_s <<< 2) + r_s - g_s;
    end
    six_delta = {1'b0, delta, 2'b0} + {2'b0, delta, 1'b0};
    term_w    = term[11] ? term + signed'({1'b0, six_delta}) : term;

    // delta * 65535 written as delta * 65536 - delta.
    s_num = {delta, 16'b0} - {16'b0, delta};

    nxt.hrem  = term_w[10:0];
    nxt.hdiv  = six_delta;
    nxt.hquo  = '0;
    nxt.srem  = s_num[23:16];
    nxt.sdiv  = mx;
    nxt.slow  = s_num[15:0];
    nxt.squo  = '0;
    nxt.value = mx;
    nxt.alpha = up_word_i.alpha_in;
    nxt.gray  = (delta == 8'd0);
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= nxt;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

@@ design/rhp_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhp_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           up_valid_i,
  input  rhp_pkg::cell_t up_data_i,
  output logic           up_ready_o,
  output logic           dn_valid_o,
  output rhp_pkg::cell_t dn_data_o,
  input  logic           dn_ready_i
);

  logic [11:0]    h_rem2, h_sub;
  logic           h_ge;
  logic [8:0]     s_rem2, s_sub;
  logic           s_ge;
  rhp_pkg::cell_t nxt;
  logic           valid_q;
  rhp_pkg::cell_t data_q;

  // One restoring step of each divider: double, compare, subtract.
  always_comb begin
    nxt    = up_data_i;
    h_rem2 = {up_data_i.hrem, 1'b0};
    h_ge   = h_rem2 >= {1'b0, up_data_i.hdiv};
    h_sub  = h_rem2 - {1'b0, up_data_i.hdiv};
    s_rem2 = {up_data_i.srem, up_data_i.slow[15]};
    s_ge   = s_rem2 >= {1'b0, up_data_i.sdiv};
    s_sub  = s_rem2 - {1'b0, up_data_i.sdiv};

    nxt.hrem = h_ge ? h_sub[10:0] : h_rem2[10:0];
    nxt.hquo = {up_data_i.hquo[14:0], h_ge};
    nxt.srem = s_ge ? s_sub[7:0] : s_rem2[7:0];
    nxt.slow = {up_data_i.slow[14:0], 1'b0};
    nxt.squo = {up_data_i.squo[14:0], s_ge};
  end

  assign up_ready_o = !valid_q || dn_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (up_ready_o) begin
      valid_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      data_q <= nxt;
    end
  end

  assign dn_valid_o = valid_q;
  assign dn_data_o  = data_q;

endmodule

`default_nettype wire

@@ design/rgb_to_hsv_pixel.sv @@
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_stall_o    rhp_pkg::pix_in_t  (red, green, blue, alpha_in)
// out      output     out_valid_o / out_stall_i  rhp_pkg::pix_out_t (hue, saturation, value,
//                                                                    alpha_out)
// One word is accepted per cycle while the input is not stalled; each word passes in turn through
// the chain: one preparation stage and sixteen divider cells, one per quotient bit of hue and
// saturation.
// Reset clears only the valid flags of the stages; there is no other state to clear.
// A stall at the output holds the last stage; gaps in the chain still close, and the input is
// stalled only once every stage holds a word.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_pixel_macros.svh"

module rgb_to_hsv_pixel (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rhp_pkg::pix_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rhp_pkg::pix_out_t out_word_o
);

  localparam int unsigned NumCells = rhp_pkg::QuoBits;

  // Stage 0 is the preparation stage; stages 1 to NumCells are the divider cells.
  logic           stage_valid [NumCells+1];
  logic           stage_ready [NumCells+1];
  rhp_pkg::cell_t stage_data  [NumCells+1];
  logic           prep_ready;

  // The preparation stage finds the largest and smallest channel, the hue sector term and
  // the two divisors, and loads the first partial remainders.
  rhp_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_i),
    .up_word_i  (in_word_i),
    .up_ready_o (prep_ready),
    .dn_valid_o (stage_valid[0]),
    .dn_data_o  (stage_data[0]),
    .dn_ready_i (stage_ready[0])
  );

  assign in_stall_o = !prep_ready;

  // Each cell settles one bit of the hue quotient and one bit of the saturation quotient,
  // and passes the pixel on to its neighbour.
  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    rhp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (stage_valid[k]),
      .up_data_i  (stage_data[k]),
      .up_ready_o (stage_ready[k]),
      .dn_valid_o (stage_valid[k+1]),
      .dn_data_o  (stage_data[k+1]),
      .dn_ready_i (stage_ready[k+1])
    );
  end

  // The last cell doubles as the output register.
  assign stage_ready[NumCells] = !out_stall_i;
  assign out_valid_o           = stage_valid[NumCells];

  // When all channels are equal the hue divisor was zero, so both quotients are forced to zero.
  always_comb begin
    out_word_o.hue        = stage_data[NumCells].gray ? 16'd0 : stage_data[NumCells].hquo;
    out_word_o.saturation = stage_data[NumCells].gray ? 16'd0 : stage_data[NumCells].squo;
    out_word_o.value      = stage_data[NumCells].value;
    out_word_o.alpha_out  = stage_data[NumCells].alpha;
  end

  // The input is stalled only when the chain is full behind a stalled output.
  `RHP_ASSERT(a_stall_backs_up, in_stall_o |-> (out_valid_o && out_stall_i))
  // A black pixel has no saturation.
  `RHP_ASSERT(a_black_no_sat,
      (out_valid_o && out_word_o.value == 8'd0) |-> (out_word_o.saturation == 16'd0))
  // Zero saturation means all channels were equal, and so hue is zero as well.
  `RHP_ASSERT(a_grey_no_hue,
      (out_valid_o && out_word_o.saturation == 16'd0) |-> (out_word_o.hue == 16'd0))
  // Nothing is offered at the output while reset is applied.
  `RHP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o)

endmodule

`default_nettype wire
